// ----- design/two_stack_array_deque_macros.svh -----
// Assertion macros shared by the checker of the two-stack array deque.
`ifndef TWO_STACK_ARRAY_DEQUE_MACROS_SVH
`define TWO_STACK_ARRAY_DEQUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TSAD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deque check failed");

// Next-cycle implication, checked outside reset.
`define TSAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deque check failed");

`endif

// ----- design/tsad_pkg.sv -----
// Package of types, codes and defaults for the two-stack array deque.
package tsad_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int WORD_W    = 32;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [1:0]               req_type_t;
	typedef logic [1:0]               status_t;

	localparam req_type_t REQ_PUSH_FRONT = 2'd0;
	localparam req_type_t REQ_PUSH_BACK  = 2'd1;
	localparam req_type_t REQ_POP_FRONT  = 2'd2;
	localparam req_type_t REQ_POP_BACK   = 2'd3;

	localparam status_t STS_OK    = 2'd0;
	localparam status_t STS_FULL  = 2'd1;
	localparam status_t STS_EMPTY = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic exec;
		logic capture;
		logic shift;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pop_go;
		logic more_moves;
		logic last_move;
	} sts_t;

endpackage

// ----- design/tsad_if.sv -----
// Request and response channel interfaces of the two-stack array deque.
interface tsad_req_if;
	logic                   valid;
	logic                   ready;
	tsad_pkg::req_type_t    req_type;
	tsad_pkg::word_t        push_value;

	modport source (output valid, output req_type, output push_value, input ready);
	modport sink (input valid, input req_type, input push_value, output ready);
endinterface

interface tsad_rsp_if;
	logic                   valid;
	logic                   ready;
	tsad_pkg::word_t        pop_value;
	tsad_pkg::status_t      status;
	logic                   now_empty;
	logic                   now_full;

	modport source (output valid, output pop_value, output status, output now_empty,
		output now_full, input ready);
	modport sink (input valid, input pop_value, input status, input now_empty,
		input now_full, output ready);
endinterface

// ----- design/tsad_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tsad_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/tsad_datapath.sv -----
// Datapath of the deque: stack counts, slot memory, shift cursor and result registers.
module tsad_datapath #(
	parameter int DEPTH = tsad_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tsad_pkg::cmd_t      cmd,
	output tsad_pkg::sts_t      sts,
	input  tsad_pkg::req_type_t req_type,
	input  tsad_pkg::word_t     push_value,
	output tsad_pkg::word_t     pop_value,
	output tsad_pkg::status_t   status,
	output logic                now_empty,
	output logic                now_full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] TOP = AW'(DEPTH - 1);

	tsad_pkg::req_type_t req_q;
	tsad_pkg::word_t     val_q;
	logic [CW-1:0]       fc_q, bc_q, fc_d, bc_d;
	logic [CW-1:0]       moves_q, moves_d;
	logic [AW-1:0]       dst_q, dst_d, dst_step;
	logic                up_q, up_d;
	tsad_pkg::word_t     res_val_q, res_val_d;
	tsad_pkg::status_t   res_sts_q, res_sts_d;
	tsad_pkg::word_t     out_val_q;
	tsad_pkg::status_t   out_sts_q;
	logic                out_empty_q, out_full_q;

	logic                full, empty, is_push;
	logic [CW:0]         total;

	logic                we, re;
	logic [AW-1:0]       waddr, raddr;
	logic [tsad_pkg::WORD_W-1:0] wdata, rdata;

	assign total   = {1'b0, fc_q} + {1'b0, bc_q};
	assign full    = total >= (CW+1)'(DEPTH);
	assign empty   = (fc_q == '0) && (bc_q == '0);
	assign is_push = (req_q == tsad_pkg::REQ_PUSH_FRONT) || (req_q == tsad_pkg::REQ_PUSH_BACK);
	assign dst_step = up_q ? dst_q + AW'(1) : dst_q - AW'(1);

	assign sts.pop_go     = !is_push && !empty;
	assign sts.more_moves = moves_q != '0;
	assign sts.last_move  = moves_q == CW'(1);

	always_comb begin
		we        = 1'b0;
		waddr     = '0;
		wdata     = val_q;
		re        = 1'b0;
		raddr     = '0;
		fc_d      = fc_q;
		bc_d      = bc_q;
		moves_d   = moves_q;
		dst_d     = dst_q;
		up_d      = up_q;
		res_val_d = res_val_q;
		res_sts_d = res_sts_q;
		if (cmd.exec) begin
			res_val_d = '0;
			res_sts_d = tsad_pkg::STS_OK;
			moves_d   = '0;
			if (is_push && full) begin
				res_sts_d = tsad_pkg::STS_FULL;
			end else if (!is_push && empty) begin
				res_sts_d = tsad_pkg::STS_EMPTY;
			end else begin
				unique case (req_q)
					tsad_pkg::REQ_PUSH_FRONT: begin
						we    = 1'b1;
						waddr = fc_q[AW-1:0];
						fc_d  = fc_q + CW'(1);
					end
					tsad_pkg::REQ_PUSH_BACK: begin
						we    = 1'b1;
						waddr = TOP - bc_q[AW-1:0];
						bc_d  = bc_q + CW'(1);
					end
					tsad_pkg::REQ_POP_FRONT: begin
						re = 1'b1;
						if (fc_q != '0) begin
							raddr = AW'(fc_q - CW'(1));
							fc_d  = fc_q - CW'(1);
						end else begin
							// Take the oldest back entry and shift the rest up.
							raddr   = TOP;
							dst_d   = TOP;
							up_d    = 1'b0;
							moves_d = bc_q - CW'(1);
							bc_d    = bc_q - CW'(1);
						end
					end
					tsad_pkg::REQ_POP_BACK: begin
						re = 1'b1;
						if (bc_q != '0) begin
							raddr = TOP - AW'(bc_q - CW'(1));
							bc_d  = bc_q - CW'(1);
						end else begin
							// Take the oldest front entry and shift the rest down.
							raddr   = '0;
							dst_d   = '0;
							up_d    = 1'b1;
							moves_d = fc_q - CW'(1);
							fc_d    = fc_q - CW'(1);
						end
					end
					default: ;
				endcase
			end
		end
		if (cmd.capture) begin
			res_val_d = tsad_pkg::word_t'(rdata);
			re        = moves_q != '0;
			raddr     = dst_step;
		end
		if (cmd.shift) begin
			we      = 1'b1;
			waddr   = dst_q;
			wdata   = rdata;
			dst_d   = dst_step;
			moves_d = moves_q - CW'(1);
			re      = moves_q > CW'(1);
			raddr   = up_q ? dst_q + AW'(2) : dst_q - AW'(2);
		end
	end

	tsad_ram #(
		.WIDTH(tsad_pkg::WORD_W),
		.DEPTH(DEPTH)
	) u_tsad_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q    <= '0;
			bc_q    <= '0;
			moves_q <= '0;
		end else begin
			fc_q    <= fc_d;
			bc_q    <= bc_d;
			moves_q <= moves_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req_type;
			val_q <= push_value;
		end
		dst_q     <= dst_d;
		up_q      <= up_d;
		res_val_q <= res_val_d;
		res_sts_q <= res_sts_d;
		if (cmd.load_out) begin
			out_val_q   <= res_val_q;
			out_sts_q   <= res_sts_q;
			out_empty_q <= empty;
			out_full_q  <= full;
		end
	end

	assign pop_value = out_val_q;
	assign status    = out_sts_q;
	assign now_empty = out_empty_q;
	assign now_full  = out_full_q;

endmodule

// ----- design/tsad_ctrl.sv -----
// Controller state machine of the deque and the response valid flag.
module tsad_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output tsad_pkg::cmd_t cmd,
	input  tsad_pkg::sts_t sts
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_CAPT  = 3'd2;
	localparam logic [2:0] ST_SHIFT = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.pop_go ? ST_CAPT : ST_DONE;
			end
			ST_CAPT: begin
				cmd.capture = 1'b1;
				state_d     = sts.more_moves ? ST_SHIFT : ST_DONE;
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				if (sts.last_move) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				cmd.load_out = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			priority if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- design/two_stack_array_deque.sv -----
// Top level of the two-stack array deque: controller, datapath and channel wiring.
//
//   channel  direction  payload
//   req      sink       req_type, push_value
//   rsp      source     pop_value, status, now_empty, now_full
//
// A push, a refused request or a pop from an end whose own stack holds
// entries gives its result after the execute state, with a capture state between for a pop.
// A pop that has to take the oldest entry of the opposite stack then shifts
// that stack by one slot per cycle through the single read and write port of
// the slot memory until every remaining entry has moved; the next request is
// taken only once the result has been loaded into the output register.
// Reset clears both stack counts at once; the slot memory is never cleared.
// A result waits in the output register while the next request is already at
// work, and the controller holds only when a second result is ready first.
module two_stack_array_deque #(
	parameter int DEPTH = tsad_pkg::DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tsad_req_if.sink  req,
	tsad_rsp_if.source rsp
);

	// Command and status bundles between controller and datapath.
	tsad_pkg::cmd_t cmd;
	tsad_pkg::sts_t sts;

	// The controller sequences each request through execute and, for a pop, capture and the
	// shift loop, and owns the response valid flag.
	tsad_ctrl u_tsad_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// The datapath holds the counts, the slot memory and the result registers.
	tsad_datapath #(
		.DEPTH(DEPTH)
	) u_tsad_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req_type  (req.req_type),
		.push_value(req.push_value),
		.pop_value (rsp.pop_value),
		.status    (rsp.status),
		.now_empty (rsp.now_empty),
		.now_full  (rsp.now_full)
	);

endmodule

// ----- design/tsad_checker.sv -----
// Port-level checker of the two-stack array deque and its bind statement.
`include "two_stack_array_deque_macros.svh"

module tsad_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input tsad_pkg::word_t   pop_value,
	input tsad_pkg::status_t status,
	input logic              now_empty,
	input logic              now_full
);

	// A stalled response keeps its value and status.
	`TSAD_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(pop_value) && $stable(status))

	// One request at a time: after taking a request the block is not ready.
	`TSAD_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, req_valid && req_ready, !req_ready)

	// A refused push can only come from a full deque and returns zero.
	`TSAD_ASSERT_NOW(a_full_refusal, clk, arst_n, rsp_valid && (status == tsad_pkg::STS_FULL), now_full && (pop_value == '0))

	// A refused pop can only come from an empty deque and returns zero.
	`TSAD_ASSERT_NOW(a_empty_refusal, clk, arst_n, rsp_valid && (status == tsad_pkg::STS_EMPTY), now_empty && (pop_value == '0))

	// The deque is never empty and full at once.
	`TSAD_ASSERT_NOW(a_not_both, clk, arst_n, rsp_valid, !(now_empty && now_full))

endmodule

bind two_stack_array_deque tsad_checker u_tsad_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.pop_value(rsp.pop_value),
	.status   (rsp.status),
	.now_empty(rsp.now_empty),
	.now_full (rsp.now_full)
);

// ----- bench/two_stack_array_deque_tb.sv -----
// Self-checking testbench of the two-stack array deque with a random request mix and idling.
module two_stack_array_deque_tb;
	import tsad_pkg::*;

	localparam int DEPTH = DEPTH_DEF;

	// One request as the driver presents it on the request channel.
	typedef struct {
		req_type_t kind;
		word_t     value;
	} deque_request_t;

	// One result as it leaves the response channel.
	typedef struct packed {
		word_t   pop_value;
		status_t status;
		logic    now_empty;
		logic    now_full;
	} deque_result_t;

	logic clk;
	logic arst_n;

	tsad_req_if req_bus ();
	tsad_rsp_if rsp_bus ();

	two_stack_array_deque #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_bus),
		.rsp   (rsp_bus)
	);

	// Requests waiting to be driven, and the results that the accepted requests must give.
	deque_request_t request_backlog[$];
	deque_result_t  deque_outcomes[$];

	// Idling of the two sides, in percent of cycles, changed from one phase to the next.
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned mismatch_count;

	// Shadow copy of the deque: one array of slots shared by the two stacks, the
	// front stack growing up from slot 0 and the back stack down from the top slot.
	word_t       slot_shadow[DEPTH];
	int unsigned front_depth;
	int unsigned back_depth;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Applies one request to the shadow deque and returns the result that it must give.
	// A pop from an end whose own stack is empty takes the oldest entry of the other
	// stack, which sits at that stack's base, and slides the rest of it towards the base.
	function automatic deque_result_t deque_apply(req_type_t kind, word_t value);
		deque_result_t res;
		bit            full;
		res.pop_value = '0;
		res.status = STS_OK;
		full = (front_depth + back_depth) >= DEPTH;
		case (kind)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (full) begin
					res.status = STS_FULL;
				end else if (kind == REQ_PUSH_FRONT) begin
					slot_shadow[front_depth] = value;
					front_depth++;
				end else begin
					slot_shadow[DEPTH - 1 - back_depth] = value;
					back_depth++;
				end
			end
			REQ_POP_FRONT: begin
				if (front_depth == 0 && back_depth == 0) begin
					res.status = STS_EMPTY;
				end else if (front_depth > 0) begin
					front_depth--;
					res.pop_value = slot_shadow[front_depth];
				end else begin
					res.pop_value = slot_shadow[DEPTH - 1];
					for (int i = DEPTH - 1; i > DEPTH - int'(back_depth); i--)
						slot_shadow[i] = slot_shadow[i - 1];
					back_depth--;
				end
			end
			REQ_POP_BACK: begin
				if (front_depth == 0 && back_depth == 0) begin
					res.status = STS_EMPTY;
				end else if (back_depth > 0) begin
					res.pop_value = slot_shadow[DEPTH - back_depth];
					back_depth--;
				end else begin
					res.pop_value = slot_shadow[0];
					for (int i = 0; i + 1 < int'(front_depth); i++)
						slot_shadow[i] = slot_shadow[i + 1];
					front_depth--;
				end
			end
		endcase
		res.now_empty = (front_depth == 0 && back_depth == 0);
		res.now_full = (front_depth + back_depth) >= DEPTH;
		return res;
	endfunction

	task automatic add_request(req_type_t kind, word_t value);
		deque_request_t item;
		item.kind = kind;
		item.value = value;
		request_backlog.push_back(item);
	endtask

	// Mostly fully random words, with the corner values of the signed range now and then.
	function automatic word_t pick_value();
		if ($urandom_range(99) >= 10)
			return word_t'($urandom);
		case ($urandom_range(3))
			0: return 32'sh0000_0000;
			1: return -32'sd1;
			2: return 32'sh7FFF_FFFF;
			default: return 32'sh8000_0000;
		endcase
	endfunction

	// Request driver. A new request is put up only once the previous one has been
	// taken, so valid stays high across back-to-back requests without a dip.
	always @(posedge clk or negedge arst_n) begin : request_driver
		deque_request_t item;
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
			req_bus.req_type <= REQ_PUSH_FRONT;
			req_bus.push_value <= '0;
		end else if (!req_bus.valid || req_bus.ready) begin
			if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item = request_backlog.pop_front();
				req_bus.valid <= 1'b1;
				req_bus.req_type <= item.kind;
				req_bus.push_value <= item.value;
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
	end

	// Response back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
		end else begin
			rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor. Accepted requests are run through the shadow deque first, then any
	// accepted result is checked against the oldest outstanding prediction.
	always @(posedge clk) begin : channel_monitor
		deque_result_t want;
		deque_result_t got;
		if (arst_n) begin
			if (req_bus.valid && req_bus.ready)
				deque_outcomes.push_back(deque_apply(req_bus.req_type, req_bus.push_value));
			if (rsp_bus.valid && rsp_bus.ready) begin
				got.pop_value = rsp_bus.pop_value;
				got.status = rsp_bus.status;
				got.now_empty = rsp_bus.now_empty;
				got.now_full = rsp_bus.now_full;
				if (deque_outcomes.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result with no request outstanding: pop_value %0d status %0d empty %b full %b",
							got.pop_value, got.status, got.now_empty, got.now_full);
				end else begin
					want = deque_outcomes.pop_front();
					if (got.pop_value !== want.pop_value || got.status !== want.status ||
						got.now_empty !== want.now_empty || got.now_full !== want.now_full) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("result differs: pop_value %0d/%0d status %0d/%0d empty %b/%b full %b/%b (expected/actual)",
								want.pop_value, got.pop_value, want.status, got.status,
								want.now_empty, got.now_empty, want.now_full, got.now_full);
					end
				end
			end
		end
	end

	// Watchdog: far beyond the slowest correct run, even with every pop shifting a full stack.
	initial begin
		#2_000_000;
		$display("two_stack_array_deque: mismatch");
		$finish;
	end

	initial begin
		int unsigned remaining;
		int unsigned burst_len;
		int unsigned push_pct;
		int unsigned front_pct;
		int unsigned pop_front_pct;
		req_type_t   kind;

		// Every input of the block is known from time zero; reset is then held low and released at a falling clock edge.
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.req_type = REQ_PUSH_FRONT;
		req_bus.push_value = '0;
		rsp_bus.ready = 1'b0;
		front_depth = 0;
		back_depth = 0;
		mismatch_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
				default: begin send_idle_pct = 35; recv_stall_pct = 35; end
			endcase

			if (phase == 0) begin
				// Pops from an empty deque are refused at either end.
				add_request(REQ_POP_FRONT, 32'sh1234_5678);
				add_request(REQ_POP_BACK, -32'sd1);
				// Extremes of the word at each end, then a pop from the front stack
				// and a pop from the front when only the back stack holds an entry.
				add_request(REQ_PUSH_FRONT, 32'sh7FFF_FFFF);
				add_request(REQ_PUSH_BACK, 32'sh8000_0000);
				add_request(REQ_POP_FRONT, '0);
				add_request(REQ_POP_FRONT, '0);
				// A pop from the back with an empty back stack, shifting two front entries down.
				add_request(REQ_PUSH_FRONT, 32'sh0000_0000);
				add_request(REQ_PUSH_FRONT, -32'sd1);
				add_request(REQ_PUSH_FRONT, 32'sh5A5A_A5A5);
				add_request(REQ_POP_BACK, '0);
				// Fill to the brim from both ends, then both pushes are refused as full.
				for (int i = 0; i < DEPTH - 2; i++)
					add_request((i % 2) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, word_t'(32'h1 << (i * 2 + 1)));
				add_request(REQ_PUSH_FRONT, 32'sh0F0F_0F0F);
				add_request(REQ_PUSH_BACK, 32'shF0F0_F0F0);
				add_request(REQ_POP_BACK, '0);
			end

			// Random bursts, each leaning towards pushes or pops and towards one end,
			// so that the deque keeps running into full and empty and pops often
			// have to reach across to the other stack.
			remaining = 100;
			while (remaining > 0) begin
				burst_len = $urandom_range(30, 4);
				case ($urandom_range(2))
					0: push_pct = 85;
					1: push_pct = 50;
					default: push_pct = 15;
				endcase
				front_pct = $urandom_range(100);
				pop_front_pct = $urandom_range(100);
				for (int k = 0; k < burst_len && remaining > 0; k++) begin
					if ($urandom_range(99) < push_pct)
						kind = ($urandom_range(99) < front_pct) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
					else
						kind = ($urandom_range(99) < pop_front_pct) ? REQ_POP_FRONT : REQ_POP_BACK;
					add_request(kind, pick_value());
					remaining--;
				end
			end

			// The idling of the next phase starts once this phase's requests have gone out.
			while (request_backlog.size() != 0)
				@(posedge clk);
		end

		// Drain: every request taken, every result in, then a quiet spell long enough
		// for the longest shift to show any stray result.
		while (request_backlog.size() != 0 || req_bus.valid || deque_outcomes.size() != 0)
			@(posedge clk);
		repeat (2 * DEPTH + 8) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("two_stack_array_deque: match");
		end else begin
			$display("two_stack_array_deque: mismatch");
		end
		$finish;
	end

endmodule
